@@ src/fpa_pkg.sv @@
// package: shared types, codes and helpers for the fixed-point alu
package fpa_pkg;

  localparam int FRAC_BITS = 8;
  localparam int DIV_STEPS = 32;

  typedef enum logic [3:0] {
    OP_ADD     = 4'd0,
    OP_SUB     = 4'd1,
    OP_MUL     = 4'd2,
    OP_DIV     = 4'd3,
    OP_GT      = 4'd4,
    OP_LT      = 4'd5,
    OP_GE      = 4'd6,
    OP_LE      = 4'd7,
    OP_EQ      = 4'd8,
    OP_NE      = 4'd9,
    OP_MIN     = 4'd10,
    OP_MAX     = 4'd11,
    OP_INC     = 4'd12,
    OP_DEC     = 4'd13,
    OP_TOINT   = 4'd14,
    OP_FROMINT = 4'd15
  } op_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;

  typedef struct packed {
    logic        valid;
    op_t         op;
    logic [31:0] r;
    logic        flag;
    logic [1:0]  st;
    logic        neg;
    logic        ovf;
    logic        dz;
    logic [63:0] prod;
    logic [31:0] rem;
    logic [31:0] den;
    logic [31:0] low;
    logic [31:0] q;
  } pipe_t;

  typedef struct packed {
    logic [1:0]  st;
    logic [31:0] r;
  } sat_t;

  function automatic sat_t sat_mag(input logic neg, input logic [63:0] m);
    sat_t s;
    s.st = ST_OK;
    s.r  = 32'd0;
    if (neg) begin
      if (m > 64'h0000_0000_8000_0000) begin
        s.st = ST_OVF;
        s.r  = 32'h8000_0000;
      end else begin
        s.r = 32'd0 - m[31:0];
      end
    end else begin
      if (m > 64'h0000_0000_7fff_ffff) begin
        s.st = ST_OVF;
        s.r  = 32'h7fff_ffff;
      end else begin
        s.r = m[31:0];
      end
    end
    return s;
  endfunction

endpackage

@@ src/fixed_point_alu_unit.sv @@
// top level: signed fixed-point alu with a multiplier and a pipelined divider
//
// usage:
//   a transaction is taken at a rising edge with start high and busy low.
//   busy is always low: one transaction can enter every cycle.
//   in_action selects the operation, in_operand_a and in_operand_b carry
//   raw fixed-point words.
//   every transaction returns one result on out_result, out_flag and
//   out_status, strobed by out_valid for exactly one cycle.
// pipeline: every operation takes the same path through one decode stage,
//   32 divider stages of one quotient bit each and one rounding stage.
// throughput: one transaction per cycle.
// reset: synchronous active-low rst_n clears all stage valid bits; work in
//   flight is dropped and no result comes out for it.
// the receiver cannot stall: results leave in order, one per strobe.
module fixed_point_alu_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         in_action,
  input  logic signed [31:0] in_operand_a,
  input  logic signed [31:0] in_operand_b,
  output logic               out_valid,
  output logic signed [31:0] out_result,
  output logic               out_flag,
  output logic [1:0]         out_status
);

  fpa_pkg::pipe_t stg [fpa_pkg::DIV_STEPS+1];

  assign busy = 1'b0;

  fpa_pre u_pre (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_take      (start && !busy),
    .in_action    (in_action),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .pipe_o       (stg[0])
  );

  for (genvar k = 0; k < fpa_pkg::DIV_STEPS; k++) begin : g_div
    fpa_div_stage u_div (
      .clk    (clk),
      .rst_n  (rst_n),
      .pipe_i (stg[k]),
      .pipe_o (stg[k+1])
    );
  end

  fpa_post u_post (
    .clk        (clk),
    .rst_n      (rst_n),
    .pipe_i     (stg[fpa_pkg::DIV_STEPS]),
    .out_valid  (out_valid),
    .out_result (out_result),
    .out_flag   (out_flag),
    .out_status (out_status)
  );

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##34 out_valid)
    else $error("result strobe missing after transaction");

  a_divz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == fpa_pkg::ST_DIVZ) |-> out_result == 32'sd0)
    else $error("division by zero result not zero");

  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_flag) |-> (out_result == 32'sd0 && out_status == fpa_pkg::ST_OK))
    else $error("comparison carries result or status");

endmodule

@@ src/fpa_pre.sv @@
// first stage: operand decode, simple operations, multiply and divider setup
module fpa_pre (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_take,
  input  logic [3:0]          in_action,
  input  logic signed [31:0]  in_operand_a,
  input  logic signed [31:0]  in_operand_b,
  output fpa_pkg::pipe_t      pipe_o
);

  fpa_pkg::pipe_t s_r;
  fpa_pkg::pipe_t s_nxt;
  logic [31:0] mag_a;
  logic [31:0] mag_b;
  logic [63:0] num;

  always_comb begin
    mag_a = in_operand_a[31] ? 32'd0 - in_operand_a : in_operand_a;
    mag_b = in_operand_b[31] ? 32'd0 - in_operand_b : in_operand_b;
    num   = {32'd0, mag_a} << fpa_pkg::FRAC_BITS;
    s_nxt       = '0;
    s_nxt.valid = in_take;
    s_nxt.op    = fpa_pkg::op_t'(in_action);
    s_nxt.st    = fpa_pkg::ST_OK;
    s_nxt.neg   = in_operand_a[31] ^ in_operand_b[31];
    s_nxt.den   = mag_b;
    s_nxt.rem   = num[63:32];
    s_nxt.low   = num[31:0];
    s_nxt.ovf   = num[63:32] >= mag_b;
    s_nxt.dz    = (mag_b == 32'd0);
    s_nxt.prod  = 64'(mag_a) * 64'(mag_b);
    case (fpa_pkg::op_t'(in_action))
      fpa_pkg::OP_ADD: s_nxt.r = in_operand_a + in_operand_b;
      fpa_pkg::OP_SUB: s_nxt.r = in_operand_a - in_operand_b;
      fpa_pkg::OP_DIV: begin
        if (mag_b == 32'd0) s_nxt.st = fpa_pkg::ST_DIVZ;
      end
      fpa_pkg::OP_GT:  s_nxt.flag = in_operand_a > in_operand_b;
      fpa_pkg::OP_LT:  s_nxt.flag = in_operand_a < in_operand_b;
      fpa_pkg::OP_GE:  s_nxt.flag = in_operand_a >= in_operand_b;
      fpa_pkg::OP_LE:  s_nxt.flag = in_operand_a <= in_operand_b;
      fpa_pkg::OP_EQ:  s_nxt.flag = in_operand_a == in_operand_b;
      fpa_pkg::OP_NE:  s_nxt.flag = in_operand_a != in_operand_b;
      fpa_pkg::OP_MIN: s_nxt.r = (in_operand_a < in_operand_b) ? in_operand_a : in_operand_b;
      fpa_pkg::OP_MAX: s_nxt.r = (in_operand_a > in_operand_b) ? in_operand_a : in_operand_b;
      fpa_pkg::OP_INC: s_nxt.r = in_operand_a + 32'sd1;
      fpa_pkg::OP_DEC: s_nxt.r = in_operand_a - 32'sd1;
      fpa_pkg::OP_TOINT: s_nxt.r = in_operand_a >>> fpa_pkg::FRAC_BITS;
      fpa_pkg::OP_FROMINT: begin
        s_nxt.neg  = in_operand_a[31];
        s_nxt.prod = num;
      end
      default: s_nxt.r = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r.valid <= 1'b0;
    end else begin
      s_r <= s_nxt;
    end
  end

  assign pipe_o = s_r;

endmodule

@@ src/fpa_div_stage.sv @@
// one restoring divider step, one quotient bit per stage
module fpa_div_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  fpa_pkg::pipe_t pipe_i,
  output fpa_pkg::pipe_t pipe_o
);

  fpa_pkg::pipe_t s_r;
  fpa_pkg::pipe_t s_nxt;
  logic [32:0] trial;
  logic [32:0] diff;
  logic        qbit;

  always_comb begin
    trial = {pipe_i.rem, pipe_i.low[31]};
    diff  = trial - {1'b0, pipe_i.den};
    qbit  = trial >= {1'b0, pipe_i.den};
    s_nxt     = pipe_i;
    s_nxt.rem = qbit ? diff[31:0] : trial[31:0];
    s_nxt.low = {pipe_i.low[30:0], 1'b0};
    s_nxt.q   = {pipe_i.q[30:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r.valid <= 1'b0;
    end else begin
      s_r <= s_nxt;
    end
  end

  assign pipe_o = s_r;

endmodule

@@ src/fpa_post.sv @@
// last stage: rounding and saturation, result register
module fpa_post (
  input  logic               clk,
  input  logic               rst_n,
  input  fpa_pkg::pipe_t     pipe_i,
  output logic               out_valid,
  output logic signed [31:0] out_result,
  output logic               out_flag,
  output logic [1:0]         out_status
);

  localparam logic [63:0] HALF = 64'(2 ** fpa_pkg::FRAC_BITS) >> 1;

  logic        valid_r;
  logic [31:0] result_r;
  logic        flag_r;
  logic [1:0]  status_r;
  logic [31:0] result_nxt;
  logic [1:0]  status_nxt;
  logic [63:0] mul_rnd;
  logic [32:0] quo;
  fpa_pkg::sat_t s;

  always_comb begin
    mul_rnd = (pipe_i.prod + HALF) >> fpa_pkg::FRAC_BITS;
    quo     = {1'b0, pipe_i.q} + 33'({pipe_i.rem, 1'b0} >= {1'b0, pipe_i.den});
    s       = '0;
    result_nxt = pipe_i.r;
    status_nxt = pipe_i.st;
    case (pipe_i.op)
      fpa_pkg::OP_MUL: begin
        s = fpa_pkg::sat_mag(pipe_i.neg, mul_rnd);
        result_nxt = s.r;
        status_nxt = s.st;
      end
      fpa_pkg::OP_DIV: begin
        if (!pipe_i.dz) begin
          if (pipe_i.ovf) s = fpa_pkg::sat_mag(pipe_i.neg, 64'hffff_ffff_ffff);
          else s = fpa_pkg::sat_mag(pipe_i.neg, 64'(quo));
          result_nxt = s.r;
          status_nxt = s.st;
        end
      end
      fpa_pkg::OP_FROMINT: begin
        s = fpa_pkg::sat_mag(pipe_i.neg, pipe_i.prod);
        result_nxt = s.r;
        status_nxt = s.st;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= pipe_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    result_r <= result_nxt;
    flag_r   <= pipe_i.flag;
    status_r <= status_nxt;
  end

  assign out_valid  = valid_r;
  assign out_result = result_r;
  assign out_flag   = flag_r;
  assign out_status = status_r;

endmodule

@@ verif/tb_top.sv @@
// testbench for the fixed-point alu: directed and random operations checked in order
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] result;
    logic        flag;
    logic [1:0]  status;
  } alu_out_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [3:0]         in_action = '0;
  logic signed [31:0] in_operand_a = '0;
  logic signed [31:0] in_operand_b = '0;
  logic               out_valid;
  logic signed [31:0] out_result;
  logic               out_flag;
  logic [1:0]         out_status;

  alu_out_t pending_results[$];
  int       error_count = 0;
  int       idle_pct = 0;

  fixed_point_alu_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_operand_a(in_operand_a), .in_operand_b(in_operand_b),
    .out_valid(out_valid), .out_result(out_result), .out_flag(out_flag),
    .out_status(out_status)
  );

  always #6 clk = ~clk;

  function automatic logic [63:0] magnitude(input logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic [31:0] saturate(input logic neg, input logic [63:0] m,
                                           inout logic [1:0] st);
    if (neg) begin
      if (m > 64'h8000_0000) begin
        st = fpa_pkg::ST_OVF;
        return 32'h8000_0000;
      end
      return 32'd0 - m[31:0];
    end
    if (m > 64'h7fff_ffff) begin
      st = fpa_pkg::ST_OVF;
      return 32'h7fff_ffff;
    end
    return m[31:0];
  endfunction

  function automatic alu_out_t compute_alu(input fpa_pkg::op_t op,
                                           input logic signed [31:0] a,
                                           input logic signed [31:0] b);
    alu_out_t o;
    logic signed [63:0] sa, sb;
    logic [63:0] p, num, den;
    logic neg;
    sa = a;
    sb = b;
    neg = (sa < 0) != (sb < 0);
    o.result = '0;
    o.flag = 1'b0;
    o.status = fpa_pkg::ST_OK;
    case (op)
      fpa_pkg::OP_ADD: o.result = a + b;
      fpa_pkg::OP_SUB: o.result = a - b;
      fpa_pkg::OP_MUL: begin
        p = magnitude(sa) * magnitude(sb);
        if (fpa_pkg::FRAC_BITS > 0)
          p = (p + (64'd1 << (fpa_pkg::FRAC_BITS - 1))) >> fpa_pkg::FRAC_BITS;
        o.result = saturate(neg, p, o.status);
      end
      fpa_pkg::OP_DIV: begin
        if (b == 0) begin
          o.status = fpa_pkg::ST_DIVZ;
        end else begin
          num = magnitude(sa) << fpa_pkg::FRAC_BITS;
          den = magnitude(sb);
          p = (2 * num + den) / (2 * den);
          o.result = saturate(neg, p, o.status);
        end
      end
      fpa_pkg::OP_GT: o.flag = sa > sb;
      fpa_pkg::OP_LT: o.flag = sa < sb;
      fpa_pkg::OP_GE: o.flag = sa >= sb;
      fpa_pkg::OP_LE: o.flag = sa <= sb;
      fpa_pkg::OP_EQ: o.flag = sa == sb;
      fpa_pkg::OP_NE: o.flag = sa != sb;
      fpa_pkg::OP_MIN: o.result = (sa < sb) ? a : b;
      fpa_pkg::OP_MAX: o.result = (sa > sb) ? a : b;
      fpa_pkg::OP_INC: o.result = a + 1;
      fpa_pkg::OP_DEC: o.result = a - 1;
      fpa_pkg::OP_TOINT: o.result = a >>> fpa_pkg::FRAC_BITS;
      default: o.result = saturate(sa < 0, magnitude(sa) << fpa_pkg::FRAC_BITS, o.status);
    endcase
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  task automatic send_op(input fpa_pkg::op_t op, input logic [31:0] a,
                         input logic [31:0] b);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_action <= op;
    in_operand_a <= a;
    in_operand_b <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(compute_alu(op, a, b));
    @(negedge clk);
  endtask

  function automatic logic [31:0] random_word();
    case ($urandom_range(5))
      0: return $urandom_range(1) ? 32'h7fff_ffff - $urandom_range(3)
                                  : 32'h8000_0000 + $urandom_range(3);
      1: return $urandom_range(512) - 256;
      2: return ($urandom_range(200) - 100) << fpa_pkg::FRAC_BITS;
      3: return $signed($urandom_range(65535) - 32768) <<< $urandom_range(8);
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk) begin
    alu_out_t exp_out;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transaction", out_result, 32'h0);
      end else begin
        exp_out = pending_results.pop_front();
        if (out_result !== exp_out.result)
          report_mismatch("result", out_result, exp_out.result);
        if (out_flag !== exp_out.flag)
          report_mismatch("flag", {31'd0, out_flag}, {31'd0, exp_out.flag});
        if (out_status !== exp_out.status)
          report_mismatch("status", {30'd0, out_status}, {30'd0, exp_out.status});
      end
    end
  end

  task automatic test_directed();
    logic [31:0] edges[6];
    edges = '{32'h0, 32'h1, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0100};
    for (int k = 0; k < 16; k++)
      send_op(fpa_pkg::op_t'(k), edges[k % 6], edges[(k + 2) % 6]);
    send_op(fpa_pkg::OP_DIV, 32'h100, 32'h0);
    send_op(fpa_pkg::OP_MUL, 32'h7fff_ffff, 32'h7fff_ffff);
    send_op(fpa_pkg::OP_MUL, 32'h8000_0000, 32'h100);
    send_op(fpa_pkg::OP_MUL, 32'h80, 32'h1);
    send_op(fpa_pkg::OP_DIV, 32'h8000_0000, 32'hffff_ffff);
    send_op(fpa_pkg::OP_FROMINT, 32'h0080_0000, 32'h0);
    send_op(fpa_pkg::OP_TOINT, 32'hffff_ff01, 32'h0);
    send_op(fpa_pkg::OP_MIN, 32'h5, 32'h5);
    send_op(fpa_pkg::OP_EQ, 32'h8000_0000, 32'h8000_0000);
  endtask

  task automatic test_random(input int count, input int pct);
    logic [31:0] a;
    idle_pct = pct;
    for (int i = 0; i < count; i++) begin
      a = random_word();
      send_op(fpa_pkg::op_t'($urandom_range(15)), a,
              $urandom_range(7) == 0 ? a : random_word());
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(450, 0);
    test_random(300, 74);
    test_random(300, 22);
    test_random(300, 0);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (error_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #2ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
src/fpa_pkg.sv
src/fpa_pre.sv
src/fpa_div_stage.sv
src/fpa_post.sv
src/fixed_point_alu_unit.sv
verif/tb_top.sv
